[sv/line_to_vanishing_point_classifier_assert.svh]
// Assertion macros shared by the classifier.
`ifndef LINE_TO_VANISHING_POINT_CLASSIFIER_ASSERT_SVH
`define LINE_TO_VANISHING_POINT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LTVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltvp assertion failed");

// Next-cycle implication, checked out of reset.
`define LTVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltvp assertion failed");

`endif

[sv/ltvp_pkg.sv]
`default_nettype none
package ltvp_pkg;

    localparam int COORD_W  = 16;
    localparam int VP_W     = 32;
    localparam int THR_W    = 16;
    localparam int IDX_W    = 16;
    localparam int NUM_VP   = 3;
    localparam int D_W      = 17;   // endpoint difference
    localparam int W_W      = 34;   // twice midpoint-to-point vector
    localparam int P_W      = 51;   // d * w
    localparam int DOT_W    = 52;
    localparam int AD_W     = 52;
    localparam int SQ_W     = 67;   // w squared
    localparam int NW_W     = 68;
    localparam int DX2_W    = 33;
    localparam int ND_W     = 34;
    localparam int T2_W     = 32;
    localparam int D2_W     = 2 * AD_W;
    localparam int NDT_W    = ND_W + T2_W;
    localparam int CR_W     = D2_W + NW_W;
    localparam int CMP_W    = NDT_W + NW_W;
    localparam int LHS_SHIFT = 30;
    localparam int MUL_LIMB  = 32;
    localparam int MUL_TERMS = 16;
    localparam int MUL_LAT   = 5;

    localparam logic [THR_W-1:0] THR_RESET = 16'd32589;
    localparam logic [1:0]       CLUSTER_NONE = 2'd3;

    typedef enum logic [2:0] {
        CFG_VP0_X = 3'd0,
        CFG_VP0_Y = 3'd1,
        CFG_VP1_X = 3'd2,
        CFG_VP1_Y = 3'd3,
        CFG_VP2_X = 3'd4,
        CFG_VP2_Y = 3'd5,
        CFG_COS_THR = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               frame_start;
    } t_seg_in;

    typedef struct packed {
        logic [IDX_W-1:0] segment_index;
        logic [1:0]       cluster;
    } t_seg_out;

    // Segment after the front end: differences and point vectors.
    typedef struct packed {
        logic [IDX_W-1:0]            idx;
        logic [D_W-1:0]              dx;
        logic [D_W-1:0]              dy;
        logic [NUM_VP-1:0][W_W-1:0]  wx;
        logic [NUM_VP-1:0][W_W-1:0]  wy;
    } t_cls;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              zero;
        logic [NUM_VP-1:0] vld;
    } t_sb;

endpackage
`default_nettype wire

[sv/ltvp_queue.sv]
`default_nettype none
module ltvp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[sv/ltvp_front.sv]
`default_nettype none
module ltvp_front #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire ltvp_pkg::t_seg_in           i_seg,
    input  wire logic [ltvp_pkg::NUM_VP-1:0][ltvp_pkg::VP_W-1:0] i_vp_x,
    input  wire logic [ltvp_pkg::NUM_VP-1:0][ltvp_pkg::VP_W-1:0] i_vp_y,
    output ltvp_pkg::t_cls                   o_ent
);
    logic [INDEX_WIDTH-1:0]       r_cnt;
    logic [INDEX_WIDTH-1:0]       w_cur;
    logic [ltvp_pkg::D_W-1:0]     w_sx, w_sy;

    assign w_cur = i_seg.frame_start ? '0 : r_cnt;
    assign w_sx  = {1'b0, i_seg.start_x} + {1'b0, i_seg.end_x};
    assign w_sy  = {1'b0, i_seg.start_y} + {1'b0, i_seg.end_y};

    always_comb begin
        o_ent.idx = ltvp_pkg::IDX_W'(w_cur);
        o_ent.dx  = $signed({1'b0, i_seg.start_x}) - $signed({1'b0, i_seg.end_x});
        o_ent.dy  = $signed({1'b0, i_seg.start_y}) - $signed({1'b0, i_seg.end_y});
        for (int j = 0; j < ltvp_pkg::NUM_VP; j++) begin
            o_ent.wx[j] = $signed({i_vp_x[j][ltvp_pkg::VP_W-1], i_vp_x[j], 1'b0})
                        - $signed({17'b0, w_sx});
            o_ent.wy[j] = $signed({i_vp_y[j][ltvp_pkg::VP_W-1], i_vp_y[j], 1'b0})
                        - $signed({17'b0, w_sy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= w_cur + 1'b1;
        end
    end
endmodule
`default_nettype wire

[sv/ltvp_mul.sv]
`default_nettype none
module ltvp_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WA-1:0]    i_a,
    input  wire logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0]      o_p
);
    localparam int W  = WA + WB;
    localparam int LW = ltvp_pkg::MUL_LIMB;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int NP = NA * NB;

    logic [NA*LW-1:0] w_a;
    logic [NB*LW-1:0] w_b;
    logic [2*LW-1:0]  r_pp [NP];
    logic [W-1:0]     w_term [ltvp_pkg::MUL_TERMS];
    logic [W-1:0]     r_s1 [8];
    logic [W-1:0]     r_s2 [4];
    logic [W-1:0]     r_s3 [2];
    logic [W-1:0]     r_s4;

    assign w_a = (NA*LW)'(i_a);
    assign w_b = (NB*LW)'(i_b);

    // Limb products, then a registered pairwise reduction tree.
    for (genvar k = 0; k < ltvp_pkg::MUL_TERMS; k++) begin : g_pp
        if (k < NP) begin : g_on
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pp[k] <= w_a[(k / NB) * LW +: LW] * w_b[(k % NB) * LW +: LW];
                end
            end
            assign w_term[k] = W'(r_pp[k]) << (LW * ((k / NB) + (k % NB)));
        end else begin : g_off
            assign w_term[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 8; k++) begin
                r_s1[k] <= w_term[2*k] + w_term[2*k+1];
            end
            for (int k = 0; k < 4; k++) begin
                r_s2[k] <= r_s1[2*k] + r_s1[2*k+1];
            end
            for (int k = 0; k < 2; k++) begin
                r_s3[k] <= r_s2[2*k] + r_s2[2*k+1];
            end
            r_s4 <= r_s3[0] + r_s3[1];
        end
    end

    assign o_p = r_s4;
endmodule
`default_nettype wire

[sv/ltvp_back.sv]
`default_nettype none
module ltvp_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ltvp_pkg::t_cls               i_ent,
    input  wire logic                         i_ent_valid,
    output logic                              o_ent_pop,
    input  wire logic [ltvp_pkg::THR_W-1:0]   i_cos_threshold,
    output ltvp_pkg::t_seg_out                o_res,
    output logic                              o_res_push,
    input  wire logic                         i_res_full
);
    localparam int L      = ltvp_pkg::MUL_LAT;
    localparam int NV     = ltvp_pkg::NUM_VP;
    localparam int NSTG   = 3 * L + 6;
    localparam int NW_LEN = 2 * L + 3;
    localparam int NW_B   = L + 1;       // nw aligned with dot squared
    localparam int NW_S   = 2 * L + 2;   // nw aligned with pair compares
    localparam int SB_S   = 2 * L + 3;
    localparam int SB_F   = 3 * L + 4;

    logic r_vld [NSTG];
    ltvp_pkg::t_sb r_sb [NSTG];
    logic w_en;

    logic signed [ltvp_pkg::W_W-1:0]   w_wx [NV], w_wy [NV];
    logic signed [ltvp_pkg::D_W-1:0]   w_dx, w_dy;
    logic signed [2*ltvp_pkg::W_W-1:0] w_sqx [NV], w_sqy [NV];
    logic signed [2*ltvp_pkg::D_W-1:0] w_dx2, w_dy2;
    logic signed [ltvp_pkg::P_W-1:0]   r_px [NV], r_py [NV];
    logic [ltvp_pkg::SQ_W-1:0]         r_qx [NV], r_qy [NV];
    logic [ltvp_pkg::DX2_W-1:0]        r_dx2, r_dy2;
    logic signed [ltvp_pkg::DOT_W-1:0] r_dot [NV];
    logic [ltvp_pkg::ND_W-1:0]         r_nd, r_nd3;
    logic [ltvp_pkg::AD_W-1:0]         r_ad [NV];
    logic [ltvp_pkg::T2_W-1:0]         r_t2;
    logic [ltvp_pkg::NW_W-1:0]         r_nwd [NW_LEN][NV];
    logic [ltvp_pkg::D2_W-1:0]         w_d2 [NV];
    logic [ltvp_pkg::D2_W-1:0]         r_d2d [L+1][NV];
    logic [ltvp_pkg::NDT_W-1:0]        w_ndt;
    logic [ltvp_pkg::NDT_W-1:0]        r_ndtd [L+2];
    logic [ltvp_pkg::CR_W-1:0]         w_l [3], w_r [3];
    logic                              r_g [3];
    logic [NV-1:0]                     w_win;
    logic [1:0]                        w_best;
    logic [ltvp_pkg::D2_W-1:0]         w_best_d2;
    logic [ltvp_pkg::NW_W-1:0]         w_best_nw;
    logic [ltvp_pkg::NW_W-1:0]         r_best_nw;
    logic [ltvp_pkg::D2_W-1:0]         r_bd2d [L+1];
    logic [1:0]                        r_bc [L+1];
    logic [ltvp_pkg::CMP_W-1:0]        w_rhs, w_lhs;
    ltvp_pkg::t_seg_out                r_res;

    // Whole pipeline advances together; hold only when the last stage cannot drain.
    assign w_en       = !(r_vld[NSTG-1] && i_res_full);
    assign o_ent_pop  = w_en && i_ent_valid;
    assign o_res_push = w_en && r_vld[NSTG-1];
    assign o_res      = r_res;

    assign w_dx  = $signed(i_ent.dx);
    assign w_dy  = $signed(i_ent.dy);
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    for (genvar j = 0; j < NV; j++) begin : g_sq
        assign w_wx[j]  = $signed(i_ent.wx[j]);
        assign w_wy[j]  = $signed(i_ent.wy[j]);
        assign w_sqx[j] = w_wx[j] * w_wx[j];
        assign w_sqy[j] = w_wy[j] * w_wy[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_ent_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0].idx  <= i_ent.idx;
            r_sb[0].zero <= (w_dx == '0) && (w_dy == '0);
            for (int j = 0; j < NV; j++) begin
                r_sb[0].vld[j] <= !((w_wx[j] == '0) && (w_wy[j] == '0));
            end
            for (int k = 1; k < NSTG; k++) begin
                r_sb[k] <= r_sb[k-1];
            end

            // stage 1: products
            for (int j = 0; j < NV; j++) begin
                r_px[j] <= w_dx * w_wx[j];
                r_py[j] <= w_dy * w_wy[j];
                r_qx[j] <= w_sqx[j][ltvp_pkg::SQ_W-1:0];
                r_qy[j] <= w_sqy[j][ltvp_pkg::SQ_W-1:0];
            end
            r_dx2 <= w_dx2[ltvp_pkg::DX2_W-1:0];
            r_dy2 <= w_dy2[ltvp_pkg::DX2_W-1:0];

            // stage 2: sums
            for (int j = 0; j < NV; j++) begin
                r_dot[j]    <= r_px[j] + r_py[j];
                r_nwd[0][j] <= {1'b0, r_qx[j]} + {1'b0, r_qy[j]};
            end
            r_nd <= {1'b0, r_dx2} + {1'b0, r_dy2};

            // stage 3: magnitude of the dot product, threshold squared
            for (int j = 0; j < NV; j++) begin
                r_ad[j] <= r_dot[j][ltvp_pkg::DOT_W-1] ? (~r_dot[j] + 1'b1) : r_dot[j];
            end
            r_t2  <= i_cos_threshold * i_cos_threshold;
            r_nd3 <= r_nd;

            for (int k = 1; k < NW_LEN; k++) begin
                r_nwd[k] <= r_nwd[k-1];
            end
            r_d2d[0] <= w_d2;
            for (int k = 1; k < L + 1; k++) begin
                r_d2d[k] <= r_d2d[k-1];
            end
            r_ndtd[0] <= w_ndt;
            for (int k = 1; k < L + 2; k++) begin
                r_ndtd[k] <= r_ndtd[k-1];
            end

            // pair compares: does the later point beat the earlier one
            for (int p = 0; p < 3; p++) begin
                r_g[p] <= w_l[p] > w_r[p];
            end

            // select the winner
            r_best_nw <= w_best_nw;
            r_bd2d[0] <= w_best_d2;
            r_bc[0]   <= w_best;
            for (int k = 1; k < L + 1; k++) begin
                r_bd2d[k] <= r_bd2d[k-1];
                r_bc[k]   <= r_bc[k-1];
            end

            // final threshold test
            r_res.segment_index <= r_sb[SB_F].idx;
            r_res.cluster <= (!r_sb[SB_F].zero && (r_bc[L] != ltvp_pkg::CLUSTER_NONE)
                              && (w_lhs > w_rhs)) ? r_bc[L] : ltvp_pkg::CLUSTER_NONE;
        end
    end

    for (genvar j = 0; j < NV; j++) begin : g_d2
        ltvp_mul #(.WA(ltvp_pkg::AD_W), .WB(ltvp_pkg::AD_W)) u_mul_d2 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_ad[j]),
            .i_b   (r_ad[j]),
            .o_p   (w_d2[j])
        );
    end

    ltvp_mul #(.WA(ltvp_pkg::ND_W), .WB(ltvp_pkg::T2_W)) u_mul_ndt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_nd3),
        .i_b   (r_t2),
        .o_p   (w_ndt)
    );

    for (genvar p = 0; p < 3; p++) begin : g_pair
        localparam int A = (p == 2) ? 1 : 0;
        localparam int B = (p == 0) ? 1 : 2;
        ltvp_mul #(.WA(ltvp_pkg::D2_W), .WB(ltvp_pkg::NW_W)) u_mul_l (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_d2[B]),
            .i_b   (r_nwd[NW_B][A]),
            .o_p   (w_l[p])
        );
        ltvp_mul #(.WA(ltvp_pkg::D2_W), .WB(ltvp_pkg::NW_W)) u_mul_r (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_d2[A]),
            .i_b   (r_nwd[NW_B][B]),
            .o_p   (w_r[p])
        );
    end

    // First maximum among points not at the midpoint; ties go to the lower number.
    always_comb begin
        logic [NV-1:0] v;
        v = r_sb[SB_S].vld;
        w_win[0] = v[0] && !(v[1] && r_g[0]) && !(v[2] && r_g[1]);
        w_win[1] = v[1] && !(v[0] && !r_g[0]) && !(v[2] && r_g[2]);
        w_win[2] = v[2] && !(v[0] && !r_g[1]) && !(v[1] && !r_g[2]);
        w_best    = ltvp_pkg::CLUSTER_NONE;
        w_best_d2 = '0;
        w_best_nw = '0;
        for (int j = NV - 1; j >= 0; j--) begin
            if (w_win[j]) begin
                w_best    = 2'(j);
                w_best_d2 = r_d2d[L][j];
                w_best_nw = r_nwd[NW_S][j];
            end
        end
    end

    ltvp_mul #(.WA(ltvp_pkg::NDT_W), .WB(ltvp_pkg::NW_W)) u_mul_rhs (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_ndtd[L+1]),
        .i_b   (r_best_nw),
        .o_p   (w_rhs)
    );

    assign w_lhs = {r_bd2d[L], {ltvp_pkg::LHS_SHIFT{1'b0}}};
endmodule
`default_nettype wire

[sv/line_to_vanishing_point_classifier.sv]
// Classifies one line segment per clock, unless held, against three vanishing
// points and returns its index in the frame with the chosen point (0..2) or 3 for
// none. Segments enter through a short queue and run down a fixed arithmetic
// pipeline of 21 stages (product, sum and absolute-value stages, three banks of
// limb-split multipliers of 5 stages each, and compare, select and threshold
// stages); it takes a new segment every cycle and holds in place while the result
// queue is full. The user must write vanishing points and the threshold through the
// configuration port only while the block is idle; the block does not enforce this.
`default_nettype none
module line_to_vanishing_point_classifier #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire ltvp_pkg::t_seg_in           i_item,
    output logic                             empty,
    input  wire logic                        pop,
    output ltvp_pkg::t_seg_out               o_result,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [ltvp_pkg::VP_W-1:0]   i_cfg_data
);
    logic [ltvp_pkg::NUM_VP-1:0][ltvp_pkg::VP_W-1:0] r_vp_x, r_vp_y;
    logic [ltvp_pkg::THR_W-1:0] r_cos_threshold;

    logic               w_accept;
    ltvp_pkg::t_cls     w_ent_in, w_ent_out;
    logic               w_mid_empty, w_ent_pop;
    ltvp_pkg::t_seg_out w_res;
    logic               w_res_push, w_out_full;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_x          <= '0;
            r_vp_y          <= '0;
            r_cos_threshold <= ltvp_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ltvp_pkg::CFG_VP0_X:   r_vp_x[0] <= i_cfg_data;
                ltvp_pkg::CFG_VP0_Y:   r_vp_y[0] <= i_cfg_data;
                ltvp_pkg::CFG_VP1_X:   r_vp_x[1] <= i_cfg_data;
                ltvp_pkg::CFG_VP1_Y:   r_vp_y[1] <= i_cfg_data;
                ltvp_pkg::CFG_VP2_X:   r_vp_x[2] <= i_cfg_data;
                ltvp_pkg::CFG_VP2_Y:   r_vp_y[2] <= i_cfg_data;
                ltvp_pkg::CFG_COS_THR: r_cos_threshold <= i_cfg_data[ltvp_pkg::THR_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    ltvp_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_seg    (i_item),
        .i_vp_x   (r_vp_x),
        .i_vp_y   (r_vp_y),
        .o_ent    (w_ent_in)
    );

    ltvp_queue #(.WIDTH($bits(ltvp_pkg::t_cls)), .DEPTH(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_ent_in),
        .o_full  (full),
        .i_pop   (w_ent_pop),
        .o_data  (w_ent_out),
        .o_empty (w_mid_empty)
    );

    ltvp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ent           (w_ent_out),
        .i_ent_valid     (!w_mid_empty),
        .o_ent_pop       (w_ent_pop),
        .i_cos_threshold (r_cos_threshold),
        .o_res           (w_res),
        .o_res_push      (w_res_push),
        .i_res_full      (w_out_full)
    );

    ltvp_queue #(.WIDTH($bits(ltvp_pkg::t_seg_out)), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`include "line_to_vanishing_point_classifier_assert.svh"

    `LTVP_ASSERT_IMP(a_res_no_overflow, i_clk, i_rst_n, w_res_push, !w_out_full)
    `LTVP_ASSERT_IMP(a_ent_no_underflow, i_clk, i_rst_n, w_ent_pop, !w_mid_empty)
    `LTVP_ASSERT_NXT(a_accept_queued, i_clk, i_rst_n, w_accept, !w_mid_empty)

endmodule
`default_nettype wire
